### hw/rtl/csps_pkg.sv
// Shared types and constants for the CAN signal pack/unpack/scale core.
`default_nettype none
package csps_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int DIV_BITS    = 4;
  localparam int DIV_STAGES  = 64 / DIV_BITS;

  typedef enum logic {
    OP_DECODE = 1'b0,
    OP_ENCODE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_ZERO_FACTOR  = 2'd1,
    ST_SATURATED    = 2'd2,
    ST_BEYOND_FRAME = 2'd3
  } status_t;

  typedef struct packed {
    logic               operation;
    logic [63:0]        frame_in;
    logic [5:0]         start_bit;
    logic [6:0]         bit_length;
    logic               big_endian;
    logic               signed_field;
    logic signed [31:0] scale_factor;
    logic signed [47:0] scale_offset;
    logic signed [63:0] physical_in;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        frame_out;
    logic signed [63:0] physical_out;
    status_t            status;
  } out_item_t;

  typedef struct packed {
    logic        op;
    logic [63:0] frame;
    logic [5:0]  ins_sh;
    logic [6:0]  len;
    logic        moto;
    logic        sgn;
    logic        err;
    logic        fzero;
    logic        qsign;
  } ctl_t;

  typedef struct packed {
    logic [63:0] pout;
    status_t     st;
  } dec_res_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [63:0] word;
  } div_acc_t;

endpackage
`default_nettype wire

### hw/rtl/csps_div.sv
// Pipelined restoring divider, 64-bit dividend by 32-bit divisor, DIV_BITS per stage.
`default_nettype none
module csps_div import csps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_v,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        out_v,
  output logic [63:0] quotient
);

  function automatic div_acc_t div_step(input div_acc_t a, input logic [31:0] dvs);
    logic [32:0] t;
    div_acc_t    r;
    r = a;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r.rem, r.word[63]};
      if (t >= {1'b0, dvs}) begin
        r.rem  = 32'(t - {1'b0, dvs});
        r.word = {r.word[62:0], 1'b1};
      end else begin
        r.rem  = t[31:0];
        r.word = {r.word[62:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic [DIV_STAGES-1:0] v_r;
  div_acc_t              acc_r   [DIV_STAGES];
  div_acc_t              acc_nxt [DIV_STAGES];
  logic [31:0]           dvs_r   [DIV_STAGES-1];
  div_acc_t              acc_in;

  assign acc_in = '{rem: 32'd0, word: dividend};

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    if (g == 0) begin : g_first
      always_comb acc_nxt[g] = div_step(acc_in, divisor);
    end else begin : g_rest
      always_comb acc_nxt[g] = div_step(acc_r[g-1], dvs_r[g-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[DIV_STAGES-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      acc_r[i] <= acc_nxt[i];
    end
    dvs_r[0] <= divisor;
    for (int i = 1; i < DIV_STAGES - 1; i++) begin
      dvs_r[i] <= dvs_r[i-1];
    end
  end

  assign out_v    = v_r[DIV_STAGES-1];
  assign quotient = acc_r[DIV_STAGES-1].word;

endmodule
`default_nettype wire

### hw/rtl/can_signal_pack_unpack_scale_core.sv
// Top level of the CAN signal pack/unpack/scale core.
//
// Usage: drive in_item and raise start for one cycle per signal; an item is
// taken at every edge where start is high and busy is low. busy stays low,
// so a new item may be presented in every cycle.
// operation selects decode (field -> raw*factor+offset) or encode
// ((physical-offset)/factor -> field ORed into the frame).
// Each result appears on out_item for exactly one cycle with out_valid high
// once its item has passed the input register, the control line and the
// output register, in input order.
// Throughput is one item per cycle; the latency is set by the 16-stage
// quotient pipeline (four quotient bits per stage) plus input, setup and
// output registers. Decode results travel alongside the quotient pipeline.
// The receiver cannot stall; results must be taken when strobed.
// Synchronous reset clears all valid bits; items in flight are dropped.
`default_nettype none
module can_signal_pack_unpack_scale_core import csps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int DEPTH     = DIV_STAGES + 1;
  localparam int DEC_DELAY = DIV_STAGES - 3;
  localparam int LATENCY   = DIV_STAGES + 3;

  function automatic logic [63:0] lenmask(input logic [6:0] len);
    return (len >= 7'd64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << len) - 64'd1);
  endfunction

  function automatic logic [63:0] bswap(input logic [63:0] a);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = a[8*(7-i) +: 8];
    end
    return r;
  endfunction

  logic acc;
  assign busy = 1'b0;
  assign acc  = start & ~busy;

  // stage 1: captured item
  logic     s1_v_r;
  in_item_t s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= in_item;
    end
  end

  // stage 1 logic: field check, extraction, operand setup
  logic [2:0]        sbyte, sib;
  logic [6:0]        len;
  logic [63:0]       mask1, raw_sh, raw_m, raw_x, mag1, off1, dmag1;
  logic              rneg1, fneg1, err1;
  logic [31:0]       fmag1;
  logic [64:0]       d1;
  logic [5:0]        ins_sh1;
  ctl_t              ctl_nxt;

  always_comb begin
    sbyte   = s1_r.start_bit[5:3];
    sib     = s1_r.start_bit[2:0];
    len     = s1_r.bit_length;
    mask1   = lenmask(len);
    err1    = (len == 7'd0) || (len > 7'd64) ||
              ({1'b0, sbyte} >= 4'(FRAME_BYTES)) ||
              (!s1_r.big_endian &&
               ((8'(s1_r.start_bit) + 8'(len) - 8'd1) > 8'(FRAME_BYTES * 8 - 1))) ||
              (s1_r.big_endian && (((8'(len) + 8'(sib) - 8'd1) >> 3) > 8'(sbyte)));
    ins_sh1 = s1_r.big_endian ? {~sbyte, sib} : s1_r.start_bit;
    raw_sh  = s1_r.big_endian ? (bswap(s1_r.frame_in) >> ins_sh1)
                              : (s1_r.frame_in >> ins_sh1);
    raw_m   = raw_sh & mask1;
    raw_x   = raw_m;
    if (s1_r.signed_field && (len < 7'd64) && raw_m[6'(len - 7'd1)]) begin
      raw_x = raw_m | ~mask1;
    end
    rneg1   = s1_r.signed_field && raw_x[63];
    mag1    = rneg1 ? (64'd0 - raw_x) : raw_x;
    fneg1   = s1_r.scale_factor[31];
    fmag1   = fneg1 ? (32'd0 - s1_r.scale_factor) : s1_r.scale_factor;
    off1    = {{16{s1_r.scale_offset[47]}}, s1_r.scale_offset};
    d1      = {s1_r.physical_in[63], s1_r.physical_in} - {off1[63], off1};
    dmag1   = d1[64] ? 64'(65'd0 - d1) : d1[63:0];
    ctl_nxt = '{op:     s1_r.operation,
                frame:  s1_r.frame_in,
                ins_sh: ins_sh1,
                len:    len,
                moto:   s1_r.big_endian,
                sgn:    s1_r.signed_field,
                err:    err1,
                fzero:  (s1_r.scale_factor == 32'sd0),
                qsign:  d1[64] ^ fneg1};
  end

  // control line, index 0 is stage 2
  logic [DEPTH-1:0] vld_r;
  ctl_t             ctl_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DEPTH-2:0], s1_v_r};
    end
  end

  always_ff @(posedge clk) begin
    ctl_r[0] <= ctl_nxt;
    for (int i = 1; i < DEPTH; i++) begin
      ctl_r[i] <= ctl_r[i-1];
    end
  end

  // decode datapath
  logic [63:0] mag_r, dmag_r, off_r;
  logic [31:0] fmag_r;
  logic        pneg_r, pneg3_r, pneg4_r;
  logic [63:0] pplo_r, pphi_r, off3_r, off4_r;
  logic [95:0] prod_r;
  logic [97:0] sum_r;
  dec_res_t    dres_r [DEC_DELAY];
  logic [95:0] prod_nxt;
  logic [97:0] sum_nxt;
  dec_res_t    dres_nxt;
  logic        fits;

  always_comb begin
    prod_nxt = {32'd0, pplo_r} + {pphi_r, 32'd0};
    sum_nxt  = (pneg4_r ? ~{2'b00, prod_r} : {2'b00, prod_r}) +
               {{34{off4_r[63]}}, off4_r} + {97'd0, pneg4_r};
    fits     = (sum_r[97:63] == {35{sum_r[63]}});
    dres_nxt.pout = fits ? sum_r[63:0]
                         : (sum_r[97] ? 64'h8000_0000_0000_0000
                                      : 64'h7FFF_FFFF_FFFF_FFFF);
    if (ctl_r[3].fzero) begin
      dres_nxt.st = ST_ZERO_FACTOR;
    end else if (fits) begin
      dres_nxt.st = ST_OK;
    end else begin
      dres_nxt.st = ST_SATURATED;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag1;
    fmag_r  <= fmag1;
    pneg_r  <= rneg1 ^ fneg1;
    off_r   <= off1;
    dmag_r  <= dmag1;
    pplo_r  <= mag_r[31:0] * fmag_r;
    pphi_r  <= mag_r[63:32] * fmag_r;
    pneg3_r <= pneg_r;
    off3_r  <= off_r;
    prod_r  <= prod_nxt;
    pneg4_r <= pneg3_r;
    off4_r  <= off3_r;
    sum_r   <= sum_nxt;
    dres_r[0] <= dres_nxt;
    for (int i = 1; i < DEC_DELAY; i++) begin
      dres_r[i] <= dres_r[i-1];
    end
  end

  // encode quotient
  logic        div_v;
  logic [63:0] div_q;

  csps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (vld_r[0]),
    .dividend (dmag_r),
    .divisor  (fmag_r),
    .out_v    (div_v),
    .quotient (div_q)
  );

  // final stage: encode saturation, insertion and result select
  ctl_t        cf;
  dec_res_t    df;
  logic [63:0] mask_f, half, qs, v, sh, ins;
  logic        qneg;
  status_t     st_e;
  out_item_t   out_nxt;

  always_comb begin
    cf     = ctl_r[DIV_STAGES];
    df     = dres_r[DEC_DELAY-1];
    mask_f = lenmask(cf.len);
    half   = 64'd1 << 6'(cf.len - 7'd1);
    qneg   = cf.qsign && (div_q != 64'd0);
    qs     = div_q;
    st_e   = ST_OK;
    if (!cf.sgn) begin
      if (qneg) begin
        qs   = 64'd0;
        qneg = 1'b0;
        st_e = ST_SATURATED;
      end else if (div_q > mask_f) begin
        qs   = mask_f;
        st_e = ST_SATURATED;
      end
    end else begin
      if (!qneg && (div_q > half - 64'd1)) begin
        qs   = half - 64'd1;
        st_e = ST_SATURATED;
      end else if (qneg && (div_q > half)) begin
        qs   = half;
        st_e = ST_SATURATED;
      end
    end
    v   = (qneg ? (64'd0 - qs) : qs) & mask_f;
    sh  = v << cf.ins_sh;
    ins = cf.moto ? bswap(sh) : sh;
    out_nxt.frame_out    = cf.frame;
    out_nxt.physical_out = 64'sd0;
    out_nxt.status       = ST_OK;
    if (cf.err) begin
      out_nxt.status = ST_BEYOND_FRAME;
    end else if (cf.op == OP_DECODE) begin
      out_nxt.physical_out = df.pout;
      out_nxt.status       = df.st;
    end else if (cf.fzero) begin
      out_nxt.status = ST_ZERO_FACTOR;
    end else begin
      out_nxt.frame_out = cf.frame | ins;
      out_nxt.status    = st_e;
    end
  end

  logic      out_valid_r;
  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef NO_ASSERTIONS
  a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
    div_v == vld_r[DIV_STAGES])
    else $error("quotient pipeline out of step with control line");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##LATENCY out_valid)
    else $error("result missing at fixed latency");

  a_beyond_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_BEYOND_FRAME) |-> out_item.physical_out == 64'sd0)
    else $error("field beyond frame with nonzero physical value");
`endif

endmodule
`default_nettype wire
